### rtl/far_pkg.sv
package far_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_BITS = 33;
  localparam int OPCODE_BITS = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4,
    OP_DEC = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } back_state_t;

endpackage

### rtl/far_front.sv
module far_front #(
  parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [far_pkg::OPCODE_BITS-1:0] in_opcode,
  input  logic [15:0]                   in_first_num,
  input  logic [15:0]                   in_first_den,
  input  logic [15:0]                   in_second_num,
  input  logic [15:0]                   in_second_den,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [2*OPERAND_WIDTH+3-1:0]  q_mul_a,
  output logic [2*OPERAND_WIDTH+3-1:0]  q_mul_b,
  output logic [2*OPERAND_WIDTH+3-1:0]  q_mul_c,
  output logic [2*OPERAND_WIDTH+3-1:0]  q_mul_d,
  output logic [2:0]                    q_kind
);
  // Kind: bit0 reduce, bit1 subtract, bit2 single product term for numerator.
  localparam int W = OPERAND_WIDTH;
  localparam int XW = 2 * W + 3;
  localparam int D = far_pkg::QUEUE_DEPTH;
  localparam int EW = 4 * XW + 3;

  logic [EW-1:0] mem_r [D];
  logic [$clog2(D)-1:0] wp_r, rp_r;
  logic [$clog2(D):0] cnt_r;
  logic [XW-1:0] n1, d1, n2, d2, a, b, c, dd;
  logic [2:0] kind;
  logic push, pop;

  // An operand is the low W bits of its 16-bit field, sign-extended.
  function automatic logic [XW-1:0] sx(input logic [15:0] v);
    logic [31:0] z;
    z = {16'b0, v};
    sx = XW'($signed(z[W-1:0]));
  endfunction

  always_comb begin
    n1 = sx(in_first_num);
    d1 = sx(in_first_den);
    n2 = sx(in_second_num);
    d2 = sx(in_second_den);
    a = '0; b = '0; c = '0; dd = '0; kind = 3'b100;
    case (in_opcode)
      far_pkg::OP_ADD: begin a = n1; b = d2; c = n2; dd = d1; kind = 3'b001; end
      far_pkg::OP_SUB: begin a = n1; b = d2; c = n2; dd = d1; kind = 3'b011; end
      far_pkg::OP_MUL: begin a = n1; b = n2; c = d1; dd = d2; kind = 3'b101; end
      far_pkg::OP_DIV: begin a = n1; b = d2; c = d1; dd = n2; kind = 3'b101; end
      far_pkg::OP_INC: begin a = n1 + d1; b = XW'(1); c = d1; dd = XW'(1); kind = 3'b100; end
      far_pkg::OP_DEC: begin a = n1 - d1; b = XW'(1); c = d1; dd = XW'(1); kind = 3'b100; end
      default: begin a = '0; b = '0; c = '0; dd = '0; kind = 3'b100; end
    endcase
  end

  assign in_ready = (cnt_r != ($clog2(D)+1)'(D));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign {q_kind, q_mul_d, q_mul_c, q_mul_b, q_mul_a} = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {kind, dd, c, b, a};
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(D)+1)'(push) - ($clog2(D)+1)'(pop);
    end
  end
endmodule

### rtl/far_back.sv
module far_back #(
  parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic [2*OPERAND_WIDTH+3-1:0] q_mul_a,
  input  logic [2*OPERAND_WIDTH+3-1:0] q_mul_b,
  input  logic [2*OPERAND_WIDTH+3-1:0] q_mul_c,
  input  logic [2*OPERAND_WIDTH+3-1:0] q_mul_d,
  input  logic [2:0]                   q_kind,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [far_pkg::RES_BITS-1:0] out_num,
  output logic [far_pkg::RES_BITS-1:0] out_den,
  output logic                         out_err
);
  localparam int W = OPERAND_WIDTH;
  localparam int XW = 2 * OPERAND_WIDTH + 3;
  localparam int RB = far_pkg::RES_BITS;
  localparam int CW = $clog2(XW + 1);

  far_pkg::back_state_t st_r, st_nxt;
  logic [XW-1:0] num_r, den_r, ga_r, gb_r, g_r, rem_r, quo_r, dv_r, a_r, b_r, c_r, d_r;
  logic [2:0] kind_r;
  logic [CW-1:0] cnt_r, sh_r;
  logic nneg_r, dneg_r, done_g;
  logic signed [2*W-1:0] p1w, p2w, p3w;
  logic [XW-1:0] p1, p2, p3, sum, mabs_n, mabs_d, trial;
  logic [XW:0] sub;

  // Multiplied operands are sign-extended W-bit values, so W by W products suffice.
  assign p1w = $signed(a_r[W-1:0]) * $signed(b_r[W-1:0]);
  assign p2w = $signed(c_r[W-1:0]) * $signed(d_r[W-1:0]);
  assign p3w = $signed(b_r[W-1:0]) * $signed(d_r[W-1:0]);
  assign p1 = XW'(p1w);
  assign p2 = XW'(p2w);
  assign p3 = XW'(p3w);
  assign sum = kind_r[2] ? p1 : (kind_r[1] ? p1 - p2 : p1 + p2);
  assign mabs_n = num_r[XW-1] ? -num_r : num_r;
  assign mabs_d = den_r[XW-1] ? -den_r : den_r;
  assign trial = {rem_r[XW-2:0], dv_r[XW-1]};
  assign sub = {1'b0, trial} - {1'b0, g_r};
  assign done_g = (gb_r == '0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      far_pkg::ST_IDLE: if (q_valid) st_nxt = far_pkg::ST_MUL;
      far_pkg::ST_MUL:  st_nxt = far_pkg::ST_GCD;
      far_pkg::ST_GCD: begin
        if (!kind_r[0] || den_r == '0) st_nxt = far_pkg::ST_OUT;
        else if (done_g) st_nxt = far_pkg::ST_DIVN;
      end
      far_pkg::ST_DIVN: if (cnt_r == CW'(XW)) st_nxt = far_pkg::ST_DIVD;
      far_pkg::ST_DIVD: if (cnt_r == CW'(XW)) st_nxt = far_pkg::ST_OUT;
      far_pkg::ST_OUT:  if (out_ready) st_nxt = far_pkg::ST_IDLE;
      default: st_nxt = far_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (st_r == far_pkg::ST_IDLE);
    out_valid = (st_r == far_pkg::ST_OUT);
    out_num = RB'($signed(num_r));
    out_den = RB'($signed(den_r));
    out_err = (den_r == '0);
  end

  always_ff @(posedge clk) begin
    case (st_r)
      far_pkg::ST_IDLE: begin
        a_r <= q_mul_a; b_r <= q_mul_b; c_r <= q_mul_c; d_r <= q_mul_d;
        kind_r <= q_kind;
      end
      far_pkg::ST_MUL: begin
        num_r <= kind_r[0] ? sum : a_r;
        den_r <= kind_r[0] ? (kind_r[2] ? p2 : p3) : c_r;
        ga_r <= '0; gb_r <= '1; sh_r <= '0; cnt_r <= '0;
      end
      far_pkg::ST_GCD: begin
        if (cnt_r == '0) begin
          ga_r <= mabs_n; gb_r <= mabs_d; cnt_r <= CW'(1);
          nneg_r <= num_r[XW-1]; dneg_r <= den_r[XW-1];
        end else if (ga_r == '0) begin
          ga_r <= gb_r; gb_r <= '0;
        end else if (!done_g) begin
          if (!ga_r[0] && !gb_r[0]) begin
            ga_r <= ga_r >> 1; gb_r <= gb_r >> 1; sh_r <= sh_r + CW'(1);
          end else if (!ga_r[0]) ga_r <= ga_r >> 1;
          else if (!gb_r[0]) gb_r <= gb_r >> 1;
          else if (ga_r >= gb_r) ga_r <= (ga_r - gb_r) >> 1;
          else gb_r <= (gb_r - ga_r) >> 1;
        end
        if (done_g && cnt_r != '0) begin
          g_r <= ga_r << sh_r;
          dv_r <= mabs_n; rem_r <= '0; quo_r <= '0; cnt_r <= '0;
        end
      end
      far_pkg::ST_DIVN, far_pkg::ST_DIVD: begin
        if (cnt_r == CW'(XW)) begin
          if (st_r == far_pkg::ST_DIVN) begin
            num_r <= nneg_r ? -quo_r : quo_r;
            dv_r <= mabs_d;
          end else begin
            den_r <= dneg_r ? -quo_r : quo_r;
          end
          rem_r <= '0; quo_r <= '0; cnt_r <= '0;
        end else begin
          rem_r <= sub[XW] ? trial : sub[XW-1:0];
          quo_r <= {quo_r[XW-2:0], ~sub[XW]};
          dv_r <= dv_r << 1;
          cnt_r <= cnt_r + CW'(1);
        end
      end
      default: ;
    endcase
    if (!rst_n) st_r <= far_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end
endmodule

### rtl/fraction_arith_reduce.sv
// Channel | Direction | Payload
// in_     | slave     | opcode, first_num, first_den, second_num, second_den
// out_    | master    | result_num, result_den, zero_den_error
// A reduced item runs a binary gcd on XW = 2*OPERAND_WIDTH+3 bit values, then
// bit-serial divisions of the numerator and then the denominator by the gcd.
// Items that are not reduced, or that have a zero denominator, skip both steps.
// A two-entry queue decouples the front from the back.
// Reset is synchronous, active low; the result holds until out_tready.
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], first_num[18:3], first_den[34:19], second_num[50:35], second_den[66:51]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_num[32:0], result_den[65:33], zero_den_error[66]
  output logic [71:0] out_tdata
);
  localparam int XW = 2 * OPERAND_WIDTH + 3;
  logic q_valid, q_ready, err;
  logic [XW-1:0] a, b, c, d;
  logic [2:0] kind;
  logic [far_pkg::RES_BITS-1:0] rn, rd;

  far_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_opcode(in_tdata[2:0]), .in_first_num(in_tdata[18:3]),
    .in_first_den(in_tdata[34:19]), .in_second_num(in_tdata[50:35]),
    .in_second_den(in_tdata[66:51]), .q_valid, .q_ready,
    .q_mul_a(a), .q_mul_b(b), .q_mul_c(c), .q_mul_d(d), .q_kind(kind));

  far_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_mul_a(a), .q_mul_b(b), .q_mul_c(c),
    .q_mul_d(d), .q_kind(kind), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_num(rn), .out_den(rd), .out_err(err));

  assign out_tdata = {5'd0, err, rd, rn};
endmodule

### test/tb_fraction_arith_reduce.sv
`timescale 1ns / 1ps

module tb_fraction_arith_reduce;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct {
    logic [32:0] num;
    logic [32:0] den;
    logic        zero_den;
  } fraction_result_t;

  class fraction_board;
    fraction_result_t pending_q[$];
    int errors = 0;

    function int outstanding();
      return pending_q.size();
    endfunction

    task report(string what, logic [32:0] got, logic [32:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function automatic void note_request(logic [2:0] op, logic signed [15:0] a_num,
                                         logic signed [15:0] a_den,
                                         logic signed [15:0] b_num,
                                         logic signed [15:0] b_den);
      longint n1, d1, n2, d2, num, den, x, y, t;
      bit reduce;
      fraction_result_t r;
      n1 = a_num;
      d1 = a_den;
      n2 = b_num;
      d2 = b_den;
      reduce = 1;
      case (op)
        far_pkg::OP_ADD: begin num = n1 * d2 + n2 * d1; den = d1 * d2; end
        far_pkg::OP_SUB: begin num = n1 * d2 - n2 * d1; den = d1 * d2; end
        far_pkg::OP_MUL: begin num = n1 * n2; den = d1 * d2; end
        far_pkg::OP_DIV: begin num = n1 * d2; den = d1 * n2; end
        far_pkg::OP_INC: begin num = n1 + d1; den = d1; reduce = 0; end
        far_pkg::OP_DEC: begin num = n1 - d1; den = d1; reduce = 0; end
        default: begin num = 0; den = 0; reduce = 0; end
      endcase
      if (den == 0) reduce = 0;
      if (reduce) begin
        x = abs64(num);
        y = abs64(den);
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        if (x != 0) begin
          num = num / x;
          den = den / x;
        end
      end
      r.num = num[32:0];
      r.den = den[32:0];
      r.zero_den = (den == 0);
      pending_q.push_back(r);
    endfunction

    task check_result(logic [71:0] data);
      fraction_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", data[32:0], 33'd0);
      end else begin
        want = pending_q.pop_front();
        if (data[32:0] !== want.num) report("result_num", data[32:0], want.num);
        if (data[65:33] !== want.den) report("result_den", data[65:33], want.den);
        if (data[66] !== want.zero_den)
          report("zero_den_error", {32'b0, data[66]}, {32'b0, want.zero_den});
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;

  fraction_board board = new();
  bit calm = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  fraction_arith_reduce DUT (.*);

  always #6 clk = ~clk;

  task send_request(logic [2:0] op, logic [15:0] a_num, logic [15:0] a_den,
                    logic [15:0] b_num, logic [15:0] b_den, bit may_idle);
    while (may_idle && !calm && $urandom_range(99) < 34) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'b0, b_den, b_num, a_den, a_num, op};
    do @(posedge clk); while (!in_tready);
    board.note_request(op, a_num, a_den, b_num, b_den);
  endtask

  task end_requests();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task drain_results();
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_opcode();
    if ($urandom_range(99) < 5) return $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
    return 3'($urandom_range(5));
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
      if (hold_req) begin
        out_tready <= 0;
        hold_cnt++;
        if (hold_cnt == 700) begin
          hold_req = 0;
          hold_cnt = 0;
        end
      end else begin
        out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_request(far_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 1);
    send_request(far_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
    send_request(far_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_request(far_pkg::OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4, 1);
    send_request(far_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1);
    send_request(far_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1);
    send_request(far_pkg::OP_MUL, 16'd0, 16'hfffd, 16'd5, 16'd7, 1);
    send_request(far_pkg::OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);
    send_request(far_pkg::OP_DIV, 16'd6, 16'd9, 16'd4, 16'hfffe, 1);
    send_request(far_pkg::OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3, 1);
    send_request(far_pkg::OP_ADD, 16'd5, 16'd0, 16'd1, 16'd3, 1);
    send_request(far_pkg::OP_INC, 16'd5, 16'd3, 16'd0, 16'd0, 1);
    send_request(far_pkg::OP_INC, 16'h7fff, 16'h7fff, 16'd1, 16'd1, 1);
    send_request(far_pkg::OP_INC, 16'd9, 16'd0, 16'd0, 16'd0, 1);
    send_request(far_pkg::OP_DEC, 16'h8000, 16'h7fff, 16'd2, 16'd2, 1);
    send_request(far_pkg::OP_DEC, 16'd4, 16'd0, 16'd0, 16'd0, 1);
    send_request(far_pkg::OP_DEC, 16'd6, 16'hfffe, 16'd0, 16'd0, 1);
    send_request(OP_UNUSED_6, 16'd1, 16'd1, 16'd1, 16'd1, 1);
    send_request(OP_UNUSED_7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);
    send_request(far_pkg::OP_SUB, 16'd0, 16'd0, 16'd0, 16'd0, 1);

    hold_req = 1;
    for (int i = 0; i < 8; i++)
      send_request(pick_opcode(), pick_operand(), pick_operand(), pick_operand(),
                   pick_operand(), 0);
    end_requests();
    drain_results();

    for (int i = 0; i < 1050; i++) begin
      calm = (i >= 400 && i < 520);
      send_request(pick_opcode(), pick_operand(), pick_operand(), pick_operand(),
                   pick_operand(), 1);
    end
    calm = 0;
    end_requests();

    drain_results();
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_fraction_arith_reduce: clean");
    end else begin
      $display("tb_fraction_arith_reduce: errors");
    end
    $finish;
  end

  initial begin
    #(12 * 3_000_000);
    $display("tb_fraction_arith_reduce: errors");
    $finish;
  end

endmodule
